// ----- sv/nps_pkg.sv -----
// Package for the nonpreemptive priority scheduler.
// Holds item structs, the task table entry, state codes and fixed widths.
// No dependencies.
`default_nettype none

package nps_pkg;

   localparam int SLOT_W  = 4;
   localparam int TIME_W  = 16;
   localparam int PRIO_W  = 8;
   localparam int CLOCK_W = 21;

   localparam logic [CLOCK_W-1:0] CLOCK_MAX = '1;

   // Item codes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] arrival_time;
      logic [TIME_W-1:0] burst_time;
      logic [PRIO_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  running_slot;
      logic               idle;
      logic [CLOCK_W-1:0] clock_now;
      logic               finished;
      logic [CLOCK_W-1:0] turnaround;
      logic [CLOCK_W-1:0] waiting;
   } rsp_type;

   // One task slot as held in the table memory
   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] remaining;
      logic [PRIO_W-1:0] prio;
   } task_entry_type;

   localparam int ENTRY_W = $bits(task_entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_SCAN_END,
      ST_EXEC,
      ST_FIN
   } sched_state_type;

endpackage

`default_nettype wire

// ----- sv/nps_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module nps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/nonpreemptive_priority_scheduler.sv -----
// Nonpreemptive priority scheduler: top level with control sequencer.
// Depends on nps_pkg and nps_ram (task table memory).
//
// Usage:
//   req channel carries load items (mode 0: write one task slot) and tick
//   items (mode 1: advance time one unit). rsp channel returns exactly one
//   result item per request item, in order.
//   A load is answered in the cycle after it is accepted. A tick while a task
//   runs reads the running slot, then updates it, with a further step when
//   the task finishes to form its waiting time. A tick with no task running
//   scans the table one slot per cycle through the memory read port, then
//   runs the picked task, with a further step to form its waiting time when
//   it finishes at once.
//   One item is worked on at a time; req_stall is high while a tick is in
//   progress or while a result item waits on a stalled rsp channel.
//   The output register frees the request side as soon as the result leaves.
//   Reset clears the clock, the running flag and the per-slot valid bits, so
//   every slot reads as empty until loaded; no clearing pass is needed.
//   While rsp_stall is high with a result held, that result item holds and no new item is taken.
`default_nettype none

module nonpreemptive_priority_scheduler #(
   parameter int MAX_TASKS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire nps_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output nps_pkg::rsp_type      rsp_item
);

   import nps_pkg::*;

   localparam int IDX_W = $clog2(MAX_TASKS);

   sched_state_type  state_ff, state_in;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [CLOCK_W-1:0] tick_ff, tick_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             found_ff, found_in;
   task_entry_type   w_ff, w_in;
   logic [IDX_W-1:0] w_idx_ff, w_idx_in;
   logic [CLOCK_W-1:0] tat_ff, tat_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_item_ff, rsp_item_in;
   logic [MAX_TASKS-1:0] valid_ff, valid_in;
   logic             rd_valid_ff;

   logic             accept;
   logic             out_free;
   logic             load_hit;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   task_entry_type   wr_data;
   logic [ENTRY_W-1:0] rd_raw;
   task_entry_type   ent;
   logic             eligible, take;
   logic [CLOCK_W-1:0] tick_next;
   logic [TIME_W-1:0]  rem_next;
   logic [CLOCK_W-1:0] arr_ext, bst_ext;

   // Task table
   nps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // Handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign load_hit  = 32'(req_item.slot) < 32'(MAX_TASKS);

   // Unloaded slots read as empty
   assign ent = rd_valid_ff ? task_entry_type'(rd_raw) : '0;

   // Selection compare for the entry returned by the last scan read
   assign eligible = (CLOCK_W'(ent.arrival) <= tick_ff) && (ent.remaining != '0);
   assign take     = cmp_vld_ff && eligible && (!found_ff || (ent.prio < w_ff.prio));

   assign tick_next = (tick_ff == CLOCK_MAX) ? tick_ff : tick_ff + CLOCK_W'(1);
   assign rem_next  = w_ff.remaining - TIME_W'(1);
   assign arr_ext   = CLOCK_W'(w_ff.arrival);
   assign bst_ext   = CLOCK_W'(w_ff.burst);

   // Next state, memory access and result formation
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      cur_in       = cur_ff;
      tick_in      = tick_ff;
      cnt_in       = cnt_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cnt_ff;
      found_in     = found_ff;
      w_in         = w_ff;
      w_idx_in     = w_idx_ff;
      tat_in       = tat_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      wr_en        = 1'b0;
      wr_addr      = w_idx_ff;
      wr_data      = '{arrival: w_ff.arrival, burst: w_ff.burst,
                       remaining: rem_next, prio: w_ff.prio};
      rd_en        = 1'b0;
      rd_addr      = cnt_ff;

      // Keep the best candidate seen so far during a scan
      if (take) begin
         found_in = 1'b1;
         w_in     = ent;
         w_idx_in = cmp_idx_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.mode == MODE_LOAD) begin
                  if (load_hit) begin
                     wr_en   = 1'b1;
                     wr_addr = IDX_W'(req_item.slot);
                     wr_data = '{arrival: req_item.arrival_time,
                                 burst: req_item.burst_time,
                                 remaining: req_item.burst_time,
                                 prio: req_item.priority_req};
                     valid_in[IDX_W'(req_item.slot)] = 1'b1;
                     // Drop the run when its slot is rewritten
                     if (busy_ff && (32'(cur_ff) == 32'(req_item.slot))) begin
                        busy_in = 1'b0;
                     end
                  end
                  rsp_valid_in = 1'b1;
                  rsp_item_in  = '{running_slot: '0, idle: 1'b1, clock_now: tick_ff,
                                   finished: 1'b0, turnaround: '0, waiting: '0};
               end else if (busy_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = cur_ff;
                  state_in = ST_READ;
               end else begin
                  found_in = 1'b0;
                  cnt_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_READ: begin
            w_in     = ent;
            w_idx_in = cur_ff;
            found_in = 1'b1;
            state_in = ST_EXEC;
         end
         ST_SCAN: begin
            rd_en      = 1'b1;
            rd_addr    = cnt_ff;
            cmp_vld_in = 1'b1;
            cmp_idx_in = cnt_ff;
            cnt_in     = cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_W'(MAX_TASKS - 1)) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            tick_in = tick_next;
            if (found_ff) begin
               wr_en   = 1'b1;
               cur_in  = w_idx_ff;
               busy_in = (rem_next != '0);
               if (rem_next == '0) begin
                  tat_in   = (tick_next >= arr_ext) ? tick_next - arr_ext : '0;
                  state_in = ST_FIN;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_item_in  = '{running_slot: SLOT_W'(w_idx_ff), idle: 1'b0,
                                   clock_now: tick_next, finished: 1'b0,
                                   turnaround: '0, waiting: '0};
                  state_in     = ST_IDLE;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{running_slot: '0, idle: 1'b1, clock_now: tick_next,
                                finished: 1'b0, turnaround: '0, waiting: '0};
               state_in     = ST_IDLE;
            end
         end
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = '{running_slot: SLOT_W'(w_idx_ff), idle: 1'b0,
                             clock_now: tick_ff, finished: 1'b1, turnaround: tat_ff,
                             waiting: (tat_ff >= bst_ext) ? tat_ff - bst_ext : '0};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         cur_ff       <= '0;
         tick_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         cur_ff       <= cur_in;
         tick_ff      <= tick_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         valid_ff     <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      cmp_idx_ff  <= cmp_idx_in;
      w_ff        <= w_in;
      w_idx_ff    <= w_idx_in;
      tat_ff      <= tat_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A result never overwrites one that is still held
   a_no_result_in_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result register occupied while a tick is in progress");

   // A finished task always reports as running
   a_finish_not_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_item_ff.finished && rsp_item_ff.idle))
      else $error("finished result flagged idle");

   // Time never runs backward
   a_clock_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (tick_ff >= $past(tick_ff)))
      else $error("tick count decreased");

   // The running slot is always a loaded slot
   a_busy_valid_slot: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> valid_ff[cur_ff])
      else $error("running slot was never loaded");

endmodule

`default_nettype wire
